/* hw/rtl/box_blur_3x3_rgb_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define BB3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also looks across reset.
`define BB3_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bb3_pkg.sv */
package bb3_pkg;

  localparam int CHAN_W         = 8;
  localparam int PIX_W          = 3 * CHAN_W;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 4;
  localparam int RESET_DIM      = 1024;

  // Neighbourhood arithmetic: 3 values of 8 bits per column, 9 per window.
  localparam int COL_SUM_W   = 10;
  localparam int SUM_W       = 12;
  // Divide by 9 as multiply by ceil(2^16 / 9) and shift; exact for sums up to 2295.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP = 13'd7282;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic              command;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    flags_t           flags;
  } job_t;

endpackage

/* hw/rtl/bb3_ram.sv */
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old word when the same address is written in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bb3_fifo.sv */
module bb3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];
  assign count   = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/bb3_front.sv */
module bb3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  bb3_pkg::in_item_t                in_data,
  input  logic                             cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             mid_full,
  output logic                             mid_push,
  output logic [$clog2(MAX_WIDTH)-1:0]     mid_col,
  output bb3_pkg::job_t                    mid_job
);
  import bb3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 4);
  localparam int RST_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
  localparam int RST_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

  logic [WW-1:0] width_r, width_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  logic [WIDTH_FIELD_W-1:0]  cfg_w_raw;
  logic [HEIGHT_FIELD_W-1:0] cfg_h_raw;
  logic [WW-1:0]             cfg_w;
  logic [HW-1:0]             cfg_h;
  logic                      cfg_hit;
  logic                      accept, filled, is_drain, take;
  logic                      emit, interior, last, col_wrap;
  logic [WW-1:0]             w_m1;
  logic [HW-1:0]             h_m1;

  assign cfg_w_raw = cfg_data[WIDTH_FIELD_W-1:0];
  assign cfg_h_raw = cfg_data[HEIGHT_FIELD_W-1:0];
  assign cfg_hit   = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // Clamp written dimensions: zero reads as one, overlarge saturates.
  always_comb begin
    priority if (cfg_w_raw == '0) begin
      cfg_w = WW'(1);
    end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
      cfg_w = WW'(MAX_WIDTH);
    end else begin
      cfg_w = WW'(cfg_w_raw);
    end
    priority if (cfg_h_raw == '0) begin
      cfg_h = HW'(1);
    end else if (32'(cfg_h_raw) > 32'(MAX_HEIGHT)) begin
      cfg_h = HW'(MAX_HEIGHT);
    end else begin
      cfg_h = HW'(cfg_h_raw);
    end
  end

  assign accept   = in_push && !mid_full;
  assign filled   = (in_row_r >= RW'(height_r));
  assign is_drain = (in_data.command == CMD_DRAIN);
  // Pixels count only before the frame is complete, drains only after.
  assign take     = accept && (is_drain == filled);

  assign w_m1     = width_r - 1'b1;
  assign h_m1     = height_r - 1'b1;
  assign col_wrap = ((WW'(in_col_r) + WW'(1)) >= width_r);
  // Nothing leaves until one row plus one pixel has gone in.
  assign emit     = !((in_row_r == '0) || (in_row_r == RW'(1) && in_col_r == '0));
  assign interior = (out_row_r != '0) && ((HW+1)'(out_row_r) + (HW+1)'(2) <= (HW+1)'(height_r))
                 && (out_col_r != '0) && ((WW+1)'(out_col_r) + (WW+1)'(2) <= (WW+1)'(width_r));
  assign last     = (out_row_r == h_m1) && (out_col_r == CW'(w_m1));

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (cfg_hit) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_nxt = cfg_w;
      end else begin
        height_nxt = cfg_h;
      end
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        priority if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_r == CW'(w_m1)) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WW'(RST_W);
      height_r  <= HW'(RST_H);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign mid_push             = take;
  assign mid_col              = in_col_r;
  assign mid_job.pix          = is_drain ? '0 : {in_data.red, in_data.green, in_data.blue};
  assign mid_job.flags.emit     = emit;
  assign mid_job.flags.interior = interior;
  assign mid_job.flags.last     = emit && last;

endmodule

/* hw/rtl/bb3_back.sv */
module bb3_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            mid_empty,
  input  logic [$clog2(MAX_WIDTH)-1:0]    mid_col,
  input  bb3_pkg::job_t                   mid_job,
  output logic                            mid_pop,
  input  logic [bb3_pkg::OUT_CNT_W-1:0]   out_count,
  output logic                            out_push,
  output bb3_pkg::out_item_t              out_item
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PROD_W = SUM_W + RECIP_W;

  // Stage 1: line store data back, window shift, line store write.
  logic             s1_v_r;
  logic [CW-1:0]    s1_col_r;
  job_t             s1_job_r;
  logic             fwd_v_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic [2*PIX_W-1:0] ram_rdata, line_rd, line_wdata;
  logic [PIX_W-1:0] win_r [9];
  logic [PIX_W-1:0] win_nxt [9];

  // Stage 2..4: column sums, window sums, scale.
  logic             s2_v_r, s3_v_r, s4_v_r;
  flags_t           s2_flags_r, s3_flags_r, s4_flags_r;
  logic [COL_SUM_W-1:0] s3_col_r [3][3];
  logic [COL_SUM_W-1:0] col_sum [3][3];
  logic [PIX_W-1:0] s3_center_r, s4_center_r;
  logic [SUM_W-1:0] s4_sum_r [3];
  logic [SUM_W-1:0] sum_nxt [3];
  logic [PROD_W-1:0] prod [3];
  logic [CHAN_W-1:0] mean [3];

  logic [2:0]           inflight;
  logic [OUT_CNT_W:0]   budget;

  // Pop only when the result queue has room for everything already in flight.
  assign inflight = 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r) + 3'(s4_v_r);
  assign budget   = (OUT_CNT_W+1)'(out_count) + (OUT_CNT_W+1)'(inflight);
  assign mid_pop  = !mid_empty && (budget < (OUT_CNT_W+1)'(OUT_DEPTH));

  bb3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (line_wdata),
    .raddr (mid_col),
    .rdata (ram_rdata)
  );

  // Upper half: two rows above, lower half: row above.
  assign line_rd    = fwd_v_r ? fwd_data_r : ram_rdata;
  assign line_wdata = {line_rd[PIX_W-1:0], s1_job_r.pix};

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_nxt[k*3]   = win_r[k*3+1];
        win_nxt[k*3+1] = win_r[k*3+2];
      end
      win_nxt[2] = line_rd[2*PIX_W-1:PIX_W];
      win_nxt[5] = line_rd[PIX_W-1:0];
      win_nxt[8] = s1_job_r.pix;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 3; c++) begin
        col_sum[ch][c] = COL_SUM_W'(win_r[c][(2-ch)*CHAN_W +: CHAN_W])
                       + COL_SUM_W'(win_r[3+c][(2-ch)*CHAN_W +: CHAN_W])
                       + COL_SUM_W'(win_r[6+c][(2-ch)*CHAN_W +: CHAN_W]);
      end
      sum_nxt[ch] = SUM_W'(s3_col_r[ch][0]) + SUM_W'(s3_col_r[ch][1])
                  + SUM_W'(s3_col_r[ch][2]);
      prod[ch]    = PROD_W'(s4_sum_r[ch]) * PROD_W'(RECIP);
      mean[ch]    = prod[ch][RECIP_SHIFT +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_v_r  <= mid_pop;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      // Same column back to back: the store has not yet seen the write.
      fwd_v_r <= s1_v_r && mid_pop && (mid_col == s1_col_r);
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r    <= mid_col;
    s1_job_r    <= mid_job;
    fwd_data_r  <= line_wdata;
    s2_flags_r  <= s1_job_r.flags;
    s3_flags_r  <= s2_flags_r;
    s3_col_r    <= col_sum;
    s3_center_r <= win_r[4];
    s4_flags_r  <= s3_flags_r;
    s4_sum_r    <= sum_nxt;
    s4_center_r <= s3_center_r;
  end

  assign out_push           = s4_v_r && s4_flags_r.emit;
  assign out_item.out_red   = s4_flags_r.interior ? mean[0] : s4_center_r[3*CHAN_W-1:2*CHAN_W];
  assign out_item.out_green = s4_flags_r.interior ? mean[1] : s4_center_r[2*CHAN_W-1:CHAN_W];
  assign out_item.out_blue  = s4_flags_r.interior ? mean[2] : s4_center_r[CHAN_W-1:0];
  assign out_item.frame_end = s4_flags_r.last;

endmodule

/* hw/rtl/box_blur_3x3_rgb.sv */
// Path: a result beat passes the job queue, stage registers s1 to s4 and the result queue.
// Throughput: one beat per cycle in steady state, pixels and drains alike, while the result queue has room.
// Rate is set by the single line store RAM: one read and one write per beat.
// Reset (rst_n low at a clock edge) empties both queues, zeroes window and counters,
// and sets width and height to 1024; line stores are not cleared, so no clearing pass.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input side: push a beat while full is low.
  input  logic                            in_push,
  output logic                            in_full,
  input  bb3_pkg::in_item_t               in_data,
  // Result side: pop the oldest beat while empty is low.
  output logic                            out_empty,
  input  logic                            out_pop,
  output bb3_pkg::out_item_t              out_data,
  // Register writes; take effect at once and restart the frame.
  input  logic                            cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bb3_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int JOB_W = $bits(job_t);
  localparam int MID_W = CW + JOB_W;
  localparam int OUT_W = $bits(out_item_t);

  // Front to back: one processed beat each, column plus job.
  logic                 fr_push;
  logic [CW-1:0]        fr_col;
  job_t                 fr_job;
  logic                 mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0]     mid_wr, mid_rd;
  logic [CW-1:0]        bk_col;
  job_t                 bk_job;

  // Back to result queue.
  logic                 res_push;
  out_item_t            res_item;
  logic [OUT_CNT_W-1:0] res_count;
  logic [OUT_W-1:0]     res_rd;

  // Front: count raster position, drop beats that do not belong, classify the
  // pixel leaving the window (border or interior, last of frame).
  bb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid_full  (mid_full),
    .mid_push  (fr_push),
    .mid_col   (fr_col),
    .mid_job   (fr_job)
  );

  // Hold input while the job queue is full; dropped beats are still taken.
  assign in_full = mid_full;
  assign mid_wr  = {fr_col, fr_job};

  // Short job queue: lets the front run on while the back waits for room.
  bb3_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty),
    .count   ()
  );

  assign bk_col = mid_rd[MID_W-1:JOB_W];
  assign bk_job = job_t'(mid_rd[JOB_W-1:0]);

  // Back: line stores, window, sums and divide by nine.
  bb3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_col   (bk_col),
    .mid_job   (bk_job),
    .mid_pop   (mid_pop),
    .out_count (res_count),
    .out_push  (res_push),
    .out_item  (res_item)
  );

  // Result queue parts the pipeline from the consumer; drain it with pop.
  bb3_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (),
    .pop     (out_pop),
    .rd_data (res_rd),
    .empty   (out_empty),
    .count   (res_count)
  );

  assign out_data = out_item_t'(res_rd);

endmodule

/* hw/rtl/bb3_checker.sv */
`include "box_blur_3x3_rgb_macros.svh"

module bb3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input bb3_pkg::out_item_t out_data
);

  // Reset leaves the result queue empty and the job queue not full.
  `BB3_ASSERT_RST(a_reset_clears, !rst_n |=> (out_empty && !in_full), "queues not empty after reset")

  // A waiting result does not vanish unless popped.
  `BB3_ASSERT(a_result_kept, (!out_empty && !out_pop) |=> !out_empty, "result lost without pop")

  // A held result beat keeps its payload.
  `BB3_ASSERT(a_result_stable, (!out_empty && !out_pop) |=> $stable(out_data), "held result changed")

  // Input side fills up only by taking a beat.
  `BB3_ASSERT(a_full_on_push, $rose(in_full) |-> $past(in_push), "full rose without a push")

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);
